[src/smt_pkg.sv]
// Shared types and constants for the session membership table.
// No dependencies; imported by the interfaces, the slot cell and the top level.
`default_nettype none

package smt_pkg;

   localparam int SLOTS_DEF = 8;   // default number of slots
   localparam int IDX_W     = 6;   // slot index width, covers up to 64 slots
   localparam int FUNC_W    = 2;
   localparam int ID_W      = 31;
   localparam int PORT_W    = 16;
   localparam int OUT_W     = 3;
   localparam int SLOT_W    = 3;   // reported slot field, low bits of the index

   typedef enum logic [1:0] {
      ST_UNUSED  = 2'd0,
      ST_OFFLINE = 2'd1,
      ST_ACTIVE  = 2'd2
   } status_type;

   typedef enum logic [FUNC_W-1:0] {
      FN_REGISTER   = 2'd0,
      FN_DISCONNECT = 2'd1,
      FN_DEREGISTER = 2'd2
   } func_type;

   typedef enum logic [OUT_W-1:0] {
      OUT_NEW      = 3'd0,
      OUT_RECON    = 3'd1,
      OUT_ACTIVE   = 3'd2,
      OUT_FULL     = 3'd3,
      OUT_DISC     = 3'd4,
      OUT_NOTFOUND = 3'd5,
      OUT_DEREG    = 3'd6
   } outcome_type;

   // Command word as it travels down the slot chain, gathering lookup results.
   typedef struct packed {
      logic              valid;
      logic [FUNC_W-1:0] func;
      logic [ID_W-1:0]   ident;
      logic [PORT_W-1:0] port;
      logic              hit;        // first matching used slot seen
      logic [IDX_W-1:0]  hit_idx;
      logic              hit_active;
      logic              free;       // some unused slot seen
      logic [IDX_W-1:0]  free_idx;   // last (highest) unused slot seen
   } tok_type;

   // Write-back broadcast to all cells at the end of a command.
   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      status_type        status;
      logic              set_port;
      logic              set_ident;
      logic [ID_W-1:0]   ident;
      logic [PORT_W-1:0] port;
   } wr_type;

endpackage

`default_nettype wire

[src/smt_if.sv]
// Valid/ready channel interfaces for command and result words.
// Depends on smt_pkg for field widths.
`default_nettype none

interface smt_req_if import smt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [ID_W-1:0]   participant_id;
   logic [PORT_W-1:0] port;

   modport source (output valid, func, participant_id, port, input ready);
   modport sink   (input valid, func, participant_id, port, output ready);
endinterface

interface smt_rsp_if import smt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [OUT_W-1:0]  outcome;
   logic [SLOT_W-1:0] slot;

   modport source (output valid, outcome, slot, input ready);
   modport sink   (input valid, outcome, slot, output ready);
endinterface

`default_nettype wire

[src/smt_cell.sv]
// One participant slot: holds status, port and identifier, and passes the
// command word on to the next slot each cycle. Depends on smt_pkg.
`default_nettype none

module smt_cell import smt_pkg::*; #(
   parameter logic [IDX_W-1:0] IDX = '0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire tok_type tok_in,
   input  wire wr_type  wr,
   output tok_type      tok_out
);

   status_type        status_ff;
   logic [PORT_W-1:0] port_ff;
   logic [ID_W-1:0]   ident_ff;
   tok_type           tok_ff, tok_in_nxt;
   logic              match;

   assign match = (status_ff != ST_UNUSED) && (ident_ff == tok_in.ident);

   always_comb begin
      tok_in_nxt = tok_in;
      if (match && !tok_in.hit) begin
         tok_in_nxt.hit        = 1'b1;
         tok_in_nxt.hit_idx    = IDX;
         tok_in_nxt.hit_active = (status_ff == ST_ACTIVE);
      end
      if (status_ff == ST_UNUSED) begin
         tok_in_nxt.free     = 1'b1;
         tok_in_nxt.free_idx = IDX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff    <= '0;
         status_ff <= ST_UNUSED;
      end else begin
         tok_ff <= tok_in_nxt;
         if (wr.en && wr.idx == IDX) status_ff <= wr.status;
      end
      if (wr.en && wr.idx == IDX && wr.set_port)  port_ff  <= wr.port;
      if (wr.en && wr.idx == IDX && wr.set_ident) ident_ff <= wr.ident;
   end

   assign tok_out = tok_ff;

endmodule

`default_nettype wire

[src/session_membership_table.sv]
// Session membership table: a chain of SLOTS slot cells scanned by one command.
// A command passes through the SLOTS cell registers, then the done register and the
// output register. One command at a time: the word walks the chain one slot per cycle
// and the next command enters once the result reaches the output register.
// Reset (synchronous) marks every slot unused at once; no clearing pass.
`default_nettype none

module session_membership_table import smt_pkg::*; #(
   parameter int SLOTS = SLOTS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   smt_req_if.sink  req,
   smt_rsp_if.source rsp
);

   // Command word entering the chain, and the chain taps between cells.
   tok_type tok_chain [SLOTS+1];
   tok_type tail;
   wr_type  wr;

   // Control: busy from accept until the result is in the output register.
   logic              busy_ff;
   logic              done_ff;
   logic [OUT_W-1:0]  done_outcome_ff, done_outcome_in;
   logic [SLOT_W-1:0] done_slot_ff, done_slot_in;
   logic              rsp_valid_ff;
   logic [OUT_W-1:0]  rsp_outcome_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              accept;
   logic              move;

   assign req.ready = !busy_ff;
   assign accept    = req.valid && !busy_ff;

   always_comb begin
      tok_chain[0]            = '0;
      tok_chain[0].valid      = accept;
      tok_chain[0].func       = req.func;
      tok_chain[0].ident      = req.participant_id;
      tok_chain[0].port       = req.port;
   end

   genvar gi;
   generate
      for (gi = 0; gi < SLOTS; gi++) begin : g_cell
         smt_cell #(.IDX(IDX_W'(gi))) u_cell (
            .clock   (clock),
            .reset   (reset),
            .tok_in  (tok_chain[gi]),
            .wr      (wr),
            .tok_out (tok_chain[gi+1])
         );
      end
   endgenerate

   assign tail = tok_chain[SLOTS];

   // Resolve the command once its word leaves the last cell; the write
   // lands in the chosen cell at the same edge the result is captured.
   always_comb begin
      wr              = '0;
      wr.ident        = tail.ident;
      wr.port         = tail.port;
      done_outcome_in = OUT_NOTFOUND;
      done_slot_in    = '0;
      case (tail.func)
         FN_REGISTER: begin
            if (tail.hit) begin
               if (!tail.hit_active) begin
                  // offline match: reconnect with the new port
                  wr.en           = tail.valid;
                  wr.idx          = tail.hit_idx;
                  wr.status       = ST_ACTIVE;
                  wr.set_port     = 1'b1;
                  done_outcome_in = OUT_RECON;
                  done_slot_in    = tail.hit_idx[SLOT_W-1:0];
               end else begin
                  done_outcome_in = OUT_ACTIVE;
               end
            end else if (tail.free) begin
               // new participant takes the highest unused slot
               wr.en           = tail.valid;
               wr.idx          = tail.free_idx;
               wr.status       = ST_ACTIVE;
               wr.set_port     = 1'b1;
               wr.set_ident    = 1'b1;
               done_outcome_in = OUT_NEW;
               done_slot_in    = tail.free_idx[SLOT_W-1:0];
            end else begin
               done_outcome_in = OUT_FULL;
            end
         end
         FN_DISCONNECT: begin
            if (tail.hit) begin
               wr.en           = tail.valid;
               wr.idx          = tail.hit_idx;
               wr.status       = ST_OFFLINE;
               done_outcome_in = OUT_DISC;
               done_slot_in    = tail.hit_idx[SLOT_W-1:0];
            end
         end
         default: begin
            // deregister; the unused func code behaves the same
            if (tail.hit) begin
               wr.en           = tail.valid;
               wr.idx          = tail.hit_idx;
               wr.status       = ST_UNUSED;
               done_outcome_in = OUT_DEREG;
               done_slot_in    = tail.hit_idx[SLOT_W-1:0];
            end
         end
      endcase
   end

   // Result moves to the output register once it is free or being taken.
   assign move = done_ff && (!rsp_valid_ff || rsp.ready);

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         done_outcome_ff <= done_outcome_in;
         done_slot_ff    <= done_slot_in;
      end
      if (move) begin
         rsp_outcome_ff <= done_outcome_ff;
         rsp_slot_ff    <= done_slot_ff;
      end
      if (reset) begin
         busy_ff      <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept)      busy_ff <= 1'b1;
         else if (move)   busy_ff <= 1'b0;
         if (tail.valid)  done_ff <= 1'b1;
         else if (move)   done_ff <= 1'b0;
         if (move)             rsp_valid_ff <= 1'b1;
         else if (rsp.ready)   rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.outcome = rsp_outcome_ff;
   assign rsp.slot    = rsp_slot_ff;

endmodule

`default_nettype wire
